@@ hdl/sitoa_pkg.sv @@
// ----------------------------------------------------------------------------
// sitoa_pkg: shared types and constants
// ascii codes and digit types used by the output channel and the converter
// ----------------------------------------------------------------------------
package sitoa_pkg;

	typedef logic [7:0] char_t;
	typedef logic [3:0] digit_t;

	// ascii codes
	localparam char_t CH_ZERO  = 8'd48;
	localparam char_t CH_NINE  = 8'd57;
	localparam char_t CH_MINUS = 8'd45;

	// decimal radix and the bcd correction threshold of the shift-add-3 step
	localparam digit_t RADIX     = 4'd10;
	localparam digit_t DD_THRESH = 4'd5;
	localparam digit_t DD_ADD    = 4'd3;

endpackage

@@ hdl/sitoa_in_if.sv @@
// ----------------------------------------------------------------------------
// sitoa_in_if: integer input channel
// valid/ready channel carrying one signed integer word
// ----------------------------------------------------------------------------
interface sitoa_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

@@ hdl/sitoa_out_if.sv @@
// ----------------------------------------------------------------------------
// sitoa_out_if: character output channel
// valid/ready channel carrying one ascii character word and a last flag
// ----------------------------------------------------------------------------
interface sitoa_out_if;
	import sitoa_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_code;
	logic  last;

	modport source (output valid, output char_code, output last, input ready);
	modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ hdl/signed_int_to_decimal_ascii.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ascii text
// pipelined double-dabble conversion followed by a character serializer
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one signed two's complement word (value, DATA_WIDTH bits) per
//   valid/ready handshake. out_ch gives its decimal text one character word at
//   a time, most significant first: '-' first for negative values, no leading
//   zeros, zero as a single '0'. last marks the final character of a number.
// path to the output
//   an accepted input word passes the input stage, DATA_WIDTH shift-add-3
//   stages, the digit search stage and the serializer load before its first
//   character sits in the output register
// throughput
//   the serializer sends one character per cycle while out_ch is not stalled;
//   a number has 1 to 11 characters at DATA_WIDTH 32, and the next number is
//   loaded in the cycle its predecessor's last character leaves the serializer
// reset and stalls
//   arst_n clears all valid bits and the serializer; no words are in flight.
//   when out_ch is stalled the output register holds its word and the
//   serializer waits; the pipeline advances while the digit search stage is
//   empty, and once a number waits there the whole pipeline freezes with in_ch.ready low
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sitoa_in_if.sink    in_ch,
	sitoa_out_if.source out_ch
);
	import sitoa_pkg::*;

	// decimal digits of the largest magnitude, 2^(DATA_WIDTH-1)
	localparam int ND = (((DATA_WIDTH - 1) * 1233) >> 12) + 1;
	localparam int BW = 4 * ND;
	localparam int PW = $clog2(ND);

	// one shift-add-3 step: correct each digit, then shift in the next bit
	function automatic logic [BW-1:0] dabble(input logic [BW-1:0] bcd_in, input logic bit_in);
		logic [BW-1:0] adj;
		digit_t        d;
		adj = '0;
		for (int i = 0; i < ND; i++) begin
			d = bcd_in[4*i +: 4];
			if (d >= DD_THRESH) begin
				d = d + DD_ADD;
			end
			adj[4*i +: 4] = d;
		end
		return {adj[BW-2:0], bit_in};
	endfunction

	// index of the most significant nonzero digit, zero for a zero value
	function automatic logic [PW-1:0] top_digit(input logic [BW-1:0] bcd_in);
		logic [PW-1:0] top;
		top = '0;
		for (int i = 0; i < ND; i++) begin
			if (bcd_in[4*i +: 4] != '0) begin
				top = PW'(i);
			end
		end
		return top;
	endfunction

	// ---------------------------------------------------------------- control
	logic adv;       // whole pipeline advances
	logic ser_take;  // serializer can load a number this cycle
	logic out_free;  // output register can take a new word
	logic fin;       // serializer sends its final character this cycle

	// ---------------------------------------------------------- stage 1: sign
	logic                  vld_s1;
	logic                  neg_s1;
	logic [DATA_WIDTH-1:0] mag_s1;

	// ------------------------------------------- stage 2: shift-add-3 rows
	logic                  vld_s2 [1:DATA_WIDTH];
	logic                  neg_s2 [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] bin_s2 [1:DATA_WIDTH];
	logic [BW-1:0]         bcd_s2 [1:DATA_WIDTH];

	// ------------------------------------------------ stage 3: digit search
	logic          vld_s3;
	logic          neg_s3;
	logic [BW-1:0] bcd_s3;
	logic [PW-1:0] top_s3;

	// ------------------------------------------------------------- serializer
	logic          busy_q;
	logic          sign_q;   // '-' still to send
	logic [PW-1:0] ptr_q;    // next digit to send
	digit_t        digits_q [ND];

	// ---------------------------------------------------------- output word
	logic  ovld_q;
	char_t ochar_q;
	logic  olast_q;

	assign out_free = !ovld_q || out_ch.ready;
	assign fin      = busy_q && out_free && !sign_q && (ptr_q == '0);
	assign ser_take = !busy_q || fin;
	assign adv      = !vld_s3 || ser_take;

	assign in_ch.ready = adv;

	// stage 1: magnitude as unsigned, exact for the most negative value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= in_ch.value[DATA_WIDTH-1];
			mag_s1 <= in_ch.value[DATA_WIDTH-1] ? (~in_ch.value + 1'b1) : in_ch.value;
		end
	end

	// stage 2: one binary bit per row, msb first
	for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_dd
		logic                  vld_in;
		logic                  neg_in;
		logic [DATA_WIDTH-1:0] bin_in;
		logic [BW-1:0]         bcd_in;

		if (k == 1) begin : g_first
			assign vld_in = vld_s1;
			assign neg_in = neg_s1;
			assign bin_in = mag_s1;
			assign bcd_in = '0;
		end else begin : g_next
			assign vld_in = vld_s2[k-1];
			assign neg_in = neg_s2[k-1];
			assign bin_in = bin_s2[k-1];
			assign bcd_in = bcd_s2[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (adv) begin
				vld_s2[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s2[k] <= neg_in;
				bin_s2[k] <= {bin_in[DATA_WIDTH-2:0], 1'b0};
				bcd_s2[k] <= dabble(bcd_in, bin_in[DATA_WIDTH-1]);
			end
		end
	end

	// stage 3: find where the text starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2[DATA_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= neg_s2[DATA_WIDTH];
			bcd_s3 <= bcd_s2[DATA_WIDTH];
			top_s3 <= top_digit(bcd_s2[DATA_WIDTH]);
		end
	end

	// serializer and output register: sign first, then digits downward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			ptr_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (out_free) begin
				ovld_q <= busy_q;
			end
			if (busy_q && out_free) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else if (ptr_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q - 1'b1;
				end
			end
			// load overrides the finishing update
			if (ser_take && vld_s3) begin
				busy_q <= 1'b1;
				sign_q <= neg_s3;
				ptr_q  <= top_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			if (sign_q) begin
				ochar_q <= CH_MINUS;
				olast_q <= 1'b0;
			end else begin
				ochar_q <= CH_ZERO + {4'b0000, digits_q[ptr_q]};
				olast_q <= (ptr_q == '0);
			end
		end
		if (ser_take && vld_s3) begin
			for (int i = 0; i < ND; i++) begin
				digits_q[i] <= bcd_s3[4*i +: 4];
			end
		end
	end

	assign out_ch.valid     = ovld_q;
	assign out_ch.char_code = ochar_q;
	assign out_ch.last      = olast_q;

	// ------------------------------------------------------------- assertions

	// a sign is never the final character of a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.char_code == CH_MINUS) |-> !out_ch.last)
		else $error("sign character flagged as last");

	// the final character is always a decimal digit
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.last |->
			(out_ch.char_code >= CH_ZERO) && (out_ch.char_code <= CH_NINE))
		else $error("last character is not a digit");

	// a number waiting for the serializer keeps its digit position
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !ser_take |=> vld_s3 && $stable(top_s3) && $stable(neg_s3))
		else $error("stalled number lost in digit search stage");

	// the serializer only starts a digit run at the top digit of a number
	a_load_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		ser_take && vld_s3 |=> busy_q && (ptr_q == $past(top_s3)))
		else $error("serializer loaded a wrong start digit");

endmodule

@@ verif/signed_int_to_decimal_ascii_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_checker: decimal text scoreboard
// spells every accepted integer word as decimal ascii and compares each
// character word leaving the converter with the oldest one still due
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_checker #(
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	sitoa_in_if  in_ch,
	sitoa_out_if out_ch,
	output int   fail_count,
	output int   chars_pending,
	output int   chars_checked
);
	import sitoa_pkg::*;

	typedef struct packed {
		char_t code;
		logic  last;
	} text_char_t;

	text_char_t chars_due[$];

	// sign first, then digits most significant first, last flag on the final digit
	function automatic void spell_decimal(input logic [DATA_WIDTH-1:0] word);
		logic [DATA_WIDTH-1:0] magnitude;
		digit_t                digits[$];
		logic                  negative;
		negative  = word[DATA_WIDTH-1];
		magnitude = negative ? (~word + 1'b1) : word;
		do begin
			digits.push_front(digit_t'(magnitude % RADIX));
			magnitude = magnitude / RADIX;
		end while (magnitude != '0);
		if (negative)
			chars_due.push_back('{CH_MINUS, 1'b0});
		foreach (digits[i])
			chars_due.push_back('{char_t'(CH_ZERO + digits[i]), i == digits.size() - 1});
	endfunction

	initial begin
		fail_count    = 0;
		chars_pending = 0;
		chars_checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		text_char_t got;
		text_char_t want;
		if (!arst_n) begin
			chars_due.delete();
			fail_count    = 0;
			chars_checked = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				spell_decimal(in_ch.value);
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.char_code, out_ch.last};
				if (chars_due.size() == 0) begin
					$display("%0t: unexpected char '%c' (%0d) last %0b", $time,
						got.code, got.code, got.last);
					fail_count++;
				end else begin
					want = chars_due.pop_front();
					if (got.code !== want.code || got.last !== want.last) begin
						$display("%0t: expected '%c' (%0d) last %0b, got '%c' (%0d) last %0b",
							$time, want.code, want.code, want.last,
							got.code, got.code, got.last);
						fail_count++;
					end
					chars_checked++;
				end
			end
		end
		chars_pending = chars_due.size();
	end

endmodule

@@ verif/signed_int_to_decimal_ascii_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: converter testbench
// drives integer words into the converter with random gaps and stalls, holds
// the character output off once so the pipeline backs up, and lets the
// checker score every character word
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;
	import sitoa_pkg::*;

	localparam int DATA_WIDTH   = 32;
	localparam int RESET_CYCLES = 5;
	localparam int HOLD_CYCLES  = 200;          // long output hold-off
	localparam int DRAIN_CYCLES = DATA_WIDTH + 16;
	localparam int STALL_LIMIT  = 2000;         // cycles with no word moving
	localparam int RANDOM_WORDS = 285;

	// zero, digit count boundaries, both extremes and their neighbors
	localparam logic signed [DATA_WIDTH-1:0] EDGE_WORDS [25] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99,
		32'sd100, -32'sd100, 32'sd12345, -32'sd67890, 32'sd999999999,
		32'sd1000000000, -32'sd1000000000, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF,
		32'sh8000_0000, 32'sh7FFF_FFFE, 32'sh5555_5555, 32'shAAAA_AAAA,
		32'sd1000000009, -32'sd123456789, 32'sd7, -32'sd5
	};

	logic clk;
	logic arst_n;

	int fail_count;
	int chars_pending;
	int chars_checked;

	// pacing knobs, written by the stimulus with nonblocking assignments
	int src_idle_pct;
	int sink_idle_pct;
	int hold_requests;

	int words_sent;
	int negatives_sent;

	sitoa_in_if #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
	sitoa_out_if out_ch ();

	signed_int_to_decimal_ascii #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	signed_int_to_decimal_ascii_checker #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_text_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fail_count   (fail_count),
		.chars_pending(chars_pending),
		.chars_checked(chars_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mix of full random words, short numbers, every decimal length and
	// words close to either extreme
	function automatic logic signed [DATA_WIDTH-1:0] random_word();
		logic [DATA_WIDTH-1:0] word;
		longint unsigned       decade;
		longint unsigned       top;
		int unsigned           ndigits;
		case ($urandom_range(0, 3))
			0: word = $urandom;
			1: begin
				word = $urandom_range(0, 120);
				if ($urandom_range(0, 1))
					word = -word;
			end
			2: begin
				ndigits = $urandom_range(1, 10);
				decade  = 1;
				repeat (ndigits - 1) decade = decade * 10;
				top = decade * 10 - 1;
				if (top > 64'h7FFF_FFFF)
					top = 64'h7FFF_FFFF;
				word = $urandom_range(int'(top), (ndigits == 1) ? 0 : int'(decade));
				if ($urandom_range(0, 1))
					word = -word;
			end
			default: begin
				if ($urandom_range(0, 1))
					word = 32'h7FFF_FFFF - $urandom_range(0, 20);
				else
					word = 32'h8000_0000 + $urandom_range(0, 20);
			end
		endcase
		return word;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic signed [DATA_WIDTH-1:0] word);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= word;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		if (word < 0)
			negatives_sent++;
		@(negedge clk);
	endtask

	// receiver: random stalls, plus a long hold whenever one is requested
	initial begin
		int hold_left;
		int hold_served;
		hold_left    = 0;
		hold_served  = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
			end
		end
	end

	// watchdog: ends the run when no word moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, quiet);
		$display("signed_int_to_decimal_ascii: mismatch");
		$finish;
	end

	// stimulus and verdict
	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.value    = '0;
		src_idle_pct   = 0;
		sink_idle_pct  = 0;
		hold_requests  = 0;
		words_sent     = 0;
		negatives_sent = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words under the first idle mix
		src_idle_pct  <= 9;
		sink_idle_pct <= 45;
		foreach (EDGE_WORDS[i])
			send_word(EDGE_WORDS[i]);

		// three idle mixes; the first opens with the long output hold so the
		// sender keeps offering words into a backed-up pipeline
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  <= 9;
					sink_idle_pct <= 45;
					hold_requests <= hold_requests + 1;
				end
				1: begin
					src_idle_pct  <= 45;
					sink_idle_pct <= 9;
				end
				default: begin
					src_idle_pct  <= 0;
					sink_idle_pct <= 0;
				end
			endcase
			repeat (RANDOM_WORDS / 3 + 1) send_word(random_word());
		end
		in_ch.valid <= 1'b0;

		// every character due, then a quiet drain for strays
		wait (chars_pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d words (%0d negative, zero and both extremes), %0d chars checked",
			words_sent, negatives_sent, chars_checked);
		$display("pacing: sender/receiver idle 9/45, 45/9, 0/0, one %0d-cycle output hold",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("signed_int_to_decimal_ascii: match");
		end else begin
			$display("%0d failures", fail_count);
			$display("signed_int_to_decimal_ascii: mismatch");
		end
		$finish;
	end

endmodule
